FILE: rtl/core/etf_pkg.sv
// Shared types, register codes and helpers for the engine hour and fuel totalizer.
// No dependencies; every other file of the block imports it.
package etf_pkg;

  localparam logic [31:0] ALL_ONES   = 32'hFFFF_FFFF;
  localparam logic [9:0]  RUN_MAX    = 10'd1023;
  localparam logic [8:0]  TENTH_LAST = 9'd359;

  localparam int unsigned IN_DATA_W  = 216;
  localparam int unsigned OUT_DATA_W = 176;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 31;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SPEED_LOW        = 3'd0,
    REG_SPEED_HIGH       = 3'd1,
    REG_TOLERANCE        = 3'd2,
    REG_RECONCILE_PERIOD = 3'd3,
    REG_SAVE_PERIOD      = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] speed_low;
    logic [15:0] speed_high;
    logic [30:0] tolerance;
    logic [9:0]  reconcile_period;
    logic [9:0]  save_period;
  } cfg_t;

  typedef struct packed {
    logic        mode;
    logic [31:0] command_value;
    logic        ignition_on;
    logic [15:0] engine_speed;
    logic [4:0]  rtc_day;
    logic [31:0] rtc_seconds;
    logic [31:0] ecu_work_time;
    logic [31:0] ecu_work_sequence;
    logic [31:0] ecu_total_fuel;
    logic [31:0] ecu_fuel_sequence;
  } in_item_t;

  typedef struct packed {
    logic [23:0]        engine_time_tenths;
    logic [23:0]        day_time_tenths;
    logic [31:0]        work_time_total;
    logic signed [31:0] work_time_offset;
    logic [31:0]        fuel_total;
    logic signed [31:0] fuel_offset_out;
    logic               persist_now;
  } out_item_t;

  // tick count kept with its quotient and remainder by 360
  typedef struct packed {
    logic [31:0] ticks;
    logic [23:0] quot;
    logic [8:0]  rem;
  } tcnt_t;

  typedef struct packed {
    logic [31:0] total;
    logic [31:0] offs;
    logic [31:0] last_seq;
  } recon_t;

  function automatic tcnt_t tick_inc(tcnt_t c);
    tcnt_t n;
    n = c;
    if (&c.ticks) begin
      n = '0;
    end else begin
      n.ticks = c.ticks + 32'd1;
      if (c.rem == TENTH_LAST) begin
        n.rem  = '0;
        n.quot = c.quot + 24'd1;
      end else begin
        n.rem = c.rem + 9'd1;
      end
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/etf_cfg.sv
// Configuration register file of the totalizer: thresholds, tolerance, periods.
// Depends on etf_pkg.
module etf_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [etf_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [etf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output etf_pkg::cfg_t                  cfg_o
);
  import etf_pkg::*;

  logic [15:0] speed_low_q, speed_high_q;
  logic [30:0] tolerance_q;
  logic [9:0]  rec_period_q, save_period_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_low_q   <= 16'd5600;
      speed_high_q  <= 16'd28000;
      tolerance_q   <= 31'd500;
      rec_period_q  <= 10'd60;
      save_period_q <= 10'd600;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SPEED_LOW:        speed_low_q   <= cfg_wdata_i[15:0];
        REG_SPEED_HIGH:       speed_high_q  <= cfg_wdata_i[15:0];
        REG_TOLERANCE:        tolerance_q   <= cfg_wdata_i;
        REG_RECONCILE_PERIOD: rec_period_q  <= cfg_wdata_i[9:0];
        REG_SAVE_PERIOD:      save_period_q <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  // a zero period acts as one
  always_comb begin
    cfg_o.speed_low        = speed_low_q;
    cfg_o.speed_high       = speed_high_q;
    cfg_o.tolerance        = tolerance_q;
    cfg_o.reconcile_period = (rec_period_q == '0) ? 10'd1 : rec_period_q;
    cfg_o.save_period      = (save_period_q == '0) ? 10'd1 : save_period_q;
  end

endmodule

FILE: rtl/core/etf_recon.sv
// Reconcile of one vehicle total and its offset against an ECU total.
// Purely combinational; depends on etf_pkg.
module etf_recon (
  input  logic          en_i,
  input  logic [31:0]   total_i,
  input  logic [31:0]   offs_i,
  input  logic [31:0]   ecu_i,
  input  logic [31:0]   seq_i,
  input  logic [31:0]   last_seq_i,
  input  logic [30:0]   tolerance_i,
  output etf_pkg::recon_t res_o
);
  import etf_pkg::*;

  logic        go;
  logic [31:0] diff, err, nerr, mag, cand;
  logic        big;

  always_comb begin
    go   = en_i && (seq_i != last_seq_i) && (ecu_i != ALL_ONES);
    diff = total_i - ecu_i;
    err  = diff - offs_i;
    nerr = offs_i - diff;
    mag  = err[31] ? nerr : err;
    big  = mag > {1'b0, tolerance_i};
    cand = ecu_i + offs_i;

    res_o.total    = total_i;
    res_o.offs     = offs_i;
    res_o.last_seq = last_seq_i;
    if (go) begin
      res_o.last_seq = seq_i;
      if (total_i == '0 || total_i == ALL_ONES) begin
        res_o.total = ecu_i;
      end else if (big) begin
        // offset absorbs the error; the candidate then equals the total
        res_o.offs = diff;
      end else if (total_i <= cand) begin
        res_o.total = cand;
      end
    end
  end

endmodule

FILE: rtl/core/etf_state.sv
// Totalizer state and its single-pass update for one tick beat.
// Depends on etf_pkg and etf_recon.
module etf_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  etf_pkg::in_item_t  item_i,
  input  etf_pkg::cfg_t      cfg_i,
  output etf_pkg::out_item_t result_o
);
  import etf_pkg::*;

  tcnt_t       eng_q, eng_d, day_q, day_d;
  logic [4:0]  sday_q, sday_d;
  logic [31:0] sep_q, sep_d;
  logic [31:0] wt_q, wt_d, wo_q, wo_d, fs_q, fs_d, fo_q, fo_d;
  logic [9:0]  run_q, run_d, phase_q, phase_d;
  logic [31:0] lws_q, lws_d, lfs_q, lfs_d;
  logic        prev_q, prev_d;

  tcnt_t       eng_b, day_b;
  logic [31:0] wt_b, wo_b, fs_b, fo_b;
  logic        new_day, running, recon, save, persist;
  recon_t      wr, fr;

  always_comb begin
    eng_b  = eng_q;
    day_b  = day_q;
    sday_d = sday_q;
    sep_d  = sep_q;
    wt_b   = wt_q;
    wo_b   = wo_q;
    fs_b   = fs_q;
    fo_b   = fo_q;
    if (item_i.mode) begin
      if (item_i.command_value == '0) begin
        eng_b  = '0;
        day_b  = '0;
        sday_d = '0;
        sep_d  = '0;
        wt_b   = '0;
        wo_b   = '0;
        fs_b   = '0;
        fo_b   = '0;
      end else begin
        wt_b = item_i.command_value;
        wo_b = '0;
      end
    end

    new_day = item_i.ignition_on && (item_i.rtc_day != sday_d)
              && (item_i.rtc_seconds >= sep_d);
    if (new_day) begin
      sday_d = item_i.rtc_day;
      sep_d  = item_i.rtc_seconds;
      day_b  = '0;
    end

    running = item_i.ignition_on && (item_i.engine_speed > cfg_i.speed_low)
              && (item_i.engine_speed < cfg_i.speed_high);
    eng_d   = running ? tick_inc(eng_b) : eng_b;
    day_d   = running ? tick_inc(day_b) : day_b;
    run_d   = (running && run_q < RUN_MAX) ? run_q + 10'd1 : run_q;
    phase_d = phase_q;
    if (running) begin
      phase_d = (phase_q >= cfg_i.reconcile_period) ? 10'd1 : phase_q + 10'd1;
    end
    recon = item_i.ignition_on && (phase_d >= cfg_i.reconcile_period);
  end

  etf_recon u_work_recon (
    .en_i        (recon),
    .total_i     (wt_b),
    .offs_i      (wo_b),
    .ecu_i       (item_i.ecu_work_time),
    .seq_i       (item_i.ecu_work_sequence),
    .last_seq_i  (lws_q),
    .tolerance_i (cfg_i.tolerance),
    .res_o       (wr)
  );

  etf_recon u_fuel_recon (
    .en_i        (recon),
    .total_i     (fs_b),
    .offs_i      (fo_b),
    .ecu_i       (item_i.ecu_total_fuel),
    .seq_i       (item_i.ecu_fuel_sequence),
    .last_seq_i  (lfs_q),
    .tolerance_i (cfg_i.tolerance),
    .res_o       (fr)
  );

  always_comb begin
    wt_d   = wr.total;
    wo_d   = wr.offs;
    lws_d  = wr.last_seq;
    fs_d   = fr.total;
    fo_d   = fr.offs;
    lfs_d  = fr.last_seq;
    prev_d = item_i.ignition_on;
    save   = (run_d >= cfg_i.save_period) || (prev_q && !item_i.ignition_on);
    persist = item_i.mode || new_day || save;

    result_o.engine_time_tenths = eng_d.quot;
    result_o.day_time_tenths    = day_d.quot;
    result_o.work_time_total    = wt_d;
    result_o.work_time_offset   = wo_d;
    result_o.fuel_total         = fs_d;
    result_o.fuel_offset_out    = fo_d;
    result_o.persist_now        = persist;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eng_q   <= '0;
      day_q   <= '0;
      sday_q  <= '0;
      sep_q   <= '0;
      wt_q    <= '0;
      wo_q    <= '0;
      fs_q    <= '0;
      fo_q    <= '0;
      run_q   <= 10'd1;
      phase_q <= 10'd1;
      lws_q   <= '0;
      lfs_q   <= '0;
      prev_q  <= 1'b0;
    end else if (step_i) begin
      eng_q   <= eng_d;
      day_q   <= day_d;
      sday_q  <= sday_d;
      sep_q   <= sep_d;
      wt_q    <= wt_d;
      wo_q    <= wo_d;
      fs_q    <= fs_d;
      fo_q    <= fo_d;
      run_q   <= save ? 10'd1 : run_d;
      phase_q <= save ? 10'd1 : phase_d;
      lws_q   <= lws_d;
      lfs_q   <= lfs_d;
      prev_q  <= prev_d;
    end
  end

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (eng_q.rem <= TENTH_LAST) && (day_q.rem <= TENTH_LAST))
    else $error("tick remainder out of range");

  a_counters_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q != '0) && (phase_q != '0))
    else $error("run counter or phase reached zero");

  a_save_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && save |=> (run_q == 10'd1) && (phase_q == 10'd1))
    else $error("save did not restart the run counter");

endmodule

FILE: rtl/core/engine_hour_fuel_totalizer.sv
// Top level of the engine hour and fuel totalizer: input beat register, state
// update and result register. Depends on etf_pkg, etf_cfg and etf_state.
//
// Usage:
//   One input beat on the s_axis group is one tick (about once a second). Each
//   tick produces exactly one result beat on the m_axis group with the engine
//   and day time in tenths of an hour, the reconciled work-time and fuel totals
//   with their offsets, and persist_now in tuser.
//   The result beat is registered: it is taken into the result register after
//   its input beat has passed the input register. Throughput is one beat per
//   cycle while m_axis_tready stays high: the input register and the result
//   register form a two-stage pipeline, and the whole state update runs
//   combinationally between them, so a new beat may follow every cycle.
//   When the receiver holds m_axis_tready low, the result register holds its
//   beat; the input register still takes one more beat, then s_axis_tready
//   drops until the result is taken.
//   Reset clears all totals, offsets, tick counts and sequence marks, sets the
//   run counter and reconcile phase to one, and loads the default thresholds
//   and periods. Write the cfg port only while no beat is in flight.
module engine_hour_fuel_totalizer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [etf_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [etf_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // command_value, ignition_on, engine_speed, rtc_day, rtc_seconds, ecu_work_time,
  // ecu_work_sequence, ecu_total_fuel, ecu_fuel_sequence, zero pad
  input  logic [etf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // mode
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // engine_time_tenths, day_time_tenths, work_time_total, work_time_offset,
  // fuel_total, fuel_offset_out
  output logic [etf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // persist_now
  output logic                            m_axis_tuser
);
  import etf_pkg::*;

  cfg_t      cfg;
  in_item_t  in_d, in_q;
  logic      in_vld_q;
  out_item_t res, out_q;
  logic      out_vld_q;
  logic      adv, take;

  always_comb begin
    in_d.mode              = s_axis_tuser;
    in_d.command_value     = s_axis_tdata[31:0];
    in_d.ignition_on       = s_axis_tdata[32];
    in_d.engine_speed      = s_axis_tdata[48:33];
    in_d.rtc_day           = s_axis_tdata[53:49];
    in_d.rtc_seconds       = s_axis_tdata[85:54];
    in_d.ecu_work_time     = s_axis_tdata[117:86];
    in_d.ecu_work_sequence = s_axis_tdata[149:118];
    in_d.ecu_total_fuel    = s_axis_tdata[181:150];
    in_d.ecu_fuel_sequence = s_axis_tdata[213:182];
  end

  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign take          = s_axis_tvalid && s_axis_tready;

  etf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  etf_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (take) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_d;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = out_q.persist_now;
  assign m_axis_tdata  = {out_q.fuel_offset_out, out_q.fuel_total, out_q.work_time_offset,
                          out_q.work_time_total, out_q.day_time_tenths,
                          out_q.engine_time_tenths};

  a_command_persists : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && in_q.mode |=> m_axis_tvalid && m_axis_tuser)
    else $error("command beat did not flag persist");

endmodule
